// ===== rtl/chacha_pkg.sv =====
`default_nettype none
package chacha_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [31:0] data_in;
        logic [2:0]  byte_count;
        logic        last_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [2:0]  out_byte_count;
        logic        out_last;
    } out_item_t;

    typedef struct packed {
        block_t      x;
        logic [31:0] ctr;
        logic [3:0]  pos;
        logic        fresh;
        in_item_t    item;
    } stage_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic block_t make_init(input logic [63:0] k01, input logic [63:0] k23,
                                         input logic [63:0] k45, input logic [63:0] k67,
                                         input logic [63:0] nonce, input logic [31:0] ctr);
        block_t b;
        b[0]  = SIGMA0;
        b[1]  = SIGMA1;
        b[2]  = SIGMA2;
        b[3]  = SIGMA3;
        b[4]  = k01[31:0];
        b[5]  = k01[63:32];
        b[6]  = k23[31:0];
        b[7]  = k23[63:32];
        b[8]  = k45[31:0];
        b[9]  = k45[63:32];
        b[10] = k67[31:0];
        b[11] = k67[63:32];
        b[12] = ctr;
        b[13] = 32'd0;
        b[14] = nonce[31:0];
        b[15] = nonce[63:32];
        make_init = b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/chacha20_stream_xor.sv =====
// ChaCha20 stream XOR, one 32-bit item per cycle while the row is not stalled.
// Each item runs down a row of 4*DOUBLE_ROUNDS half-round cells followed by the
// output register; the row accepts an item in each cycle it is not stalled,
// including the first word of each message, which starts its block there. The
// whole row stalls only while the output register holds an untaken item and the
// last cell is full. Configuration writes restart the block counter and must be
// made while no item is in flight.
`default_nettype none
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  chacha_pkg::in_item_t   in_item,
    output logic                   out_valid,
    input  wire                    out_ready,
    output chacha_pkg::out_item_t  out_item,
    input  wire                    cfg_we,
    input  wire  [2:0]             cfg_index,
    input  wire  [63:0]            cfg_data
);

    localparam int NCELL = 4 * DOUBLE_ROUNDS;

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce_reg;
    logic [31:0] counter_reg;
    logic [3:0]  pos_reg;
    logic        ready_reg;

    logic                   vld_chain [NCELL + 1];
    chacha_pkg::stage_t     stage_chain [NCELL + 1];

    logic                   out_valid_reg;
    chacha_pkg::out_item_t  out_item_reg;
    chacha_pkg::block_t     ks_reg;

    logic adv;
    logic take;
    logic cfg_hit;

    assign adv      = !(vld_chain[NCELL] && out_valid_reg && !out_ready);
    assign in_ready = adv;
    assign take     = in_valid && adv;
    assign cfg_hit  = cfg_we && (cfg_index inside {chacha_pkg::REG_KEY01,
                                                   chacha_pkg::REG_KEY23,
                                                   chacha_pkg::REG_KEY45,
                                                   chacha_pkg::REG_KEY67,
                                                   chacha_pkg::REG_NONCE});

    always_comb
    begin
        vld_chain[0]            = take;
        stage_chain[0].x        = chacha_pkg::make_init(key01_reg, key23_reg, key45_reg,
                                                        key67_reg, nonce_reg, counter_reg);
        stage_chain[0].ctr      = counter_reg;
        stage_chain[0].pos      = ready_reg ? pos_reg : 4'd0;
        stage_chain[0].fresh    = !ready_reg;
        stage_chain[0].item     = in_item;
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            chacha_cell #(
                .DIAG   ((g / 2) % 2),
                .SECOND (g % 2)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .vld_in    (vld_chain[g]),
                .stage_in  (stage_chain[g]),
                .vld_out   (vld_chain[g + 1]),
                .stage_out (stage_chain[g + 1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg   <= '0;
            key23_reg   <= '0;
            key45_reg   <= '0;
            key67_reg   <= '0;
            nonce_reg   <= '0;
            counter_reg <= '0;
            pos_reg     <= '0;
            ready_reg   <= 1'b0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                chacha_pkg::REG_KEY01: key01_reg <= cfg_data;
                chacha_pkg::REG_KEY23: key23_reg <= cfg_data;
                chacha_pkg::REG_KEY45: key45_reg <= cfg_data;
                chacha_pkg::REG_KEY67: key67_reg <= cfg_data;
                chacha_pkg::REG_NONCE: nonce_reg <= cfg_data;
                default: ;
            endcase
            counter_reg <= '0;
            pos_reg     <= '0;
            ready_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (!ready_reg)
                counter_reg <= counter_reg + 32'd1;
            pos_reg   <= in_item.last_of_message ? 4'd0 : stage_chain[0].pos + 4'd1;
            ready_reg <= !(in_item.last_of_message || stage_chain[0].pos == 4'd15);
        end
    end

    chacha_pkg::block_t ks_fresh;
    logic [31:0]        ks_word;
    logic [31:0]        mask;

    always_comb
    begin
        chacha_pkg::block_t init;
        chacha_pkg::stage_t s;
        s    = stage_chain[NCELL];
        init = chacha_pkg::make_init(key01_reg, key23_reg, key45_reg, key67_reg,
                                     nonce_reg, s.ctr);
        for (int i = 0; i < 16; i++)
            ks_fresh[i] = s.x[i] + init[i];
        ks_word = s.fresh ? ks_fresh[s.pos] : ks_reg[s.pos];
        case (s.item.byte_count)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && vld_chain[NCELL])
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_chain[NCELL])
        begin
            out_item_reg.data_out       <= (stage_chain[NCELL].item.data_in ^ ks_word) & mask;
            out_item_reg.out_byte_count <= stage_chain[NCELL].item.byte_count;
            out_item_reg.out_last       <= stage_chain[NCELL].item.last_of_message;
            if (stage_chain[NCELL].fresh)
                ks_reg <= ks_fresh;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ===== rtl/chacha_cell.sv =====
`default_nettype none
module chacha_cell #(
    parameter int DIAG   = 0,
    parameter int SECOND = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  adv,
    input  wire                  vld_in,
    input  chacha_pkg::stage_t   stage_in,
    output logic                 vld_out,
    output chacha_pkg::stage_t   stage_out
);

    localparam int ROT_D = (SECOND != 0) ? 8 : 16;
    localparam int ROT_B = (SECOND != 0) ? 7 : 12;

    logic               vld_reg;
    chacha_pkg::stage_t stage_reg;
    chacha_pkg::stage_t stage_next;

    always_comb
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        int ib;
        int ic;
        int id;
        stage_next = stage_in;
        for (int i = 0; i < 4; i++)
        begin
            ib = (DIAG != 0) ? 4 + ((i + 1) % 4) : 4 + i;
            ic = (DIAG != 0) ? 8 + ((i + 2) % 4) : 8 + i;
            id = (DIAG != 0) ? 12 + ((i + 3) % 4) : 12 + i;
            a = stage_in.x[i] + stage_in.x[ib];
            d = chacha_pkg::rotl(stage_in.x[id] ^ a, ROT_D);
            c = stage_in.x[ic] + d;
            b = chacha_pkg::rotl(stage_in.x[ib] ^ c, ROT_B);
            stage_next.x[i]  = a;
            stage_next.x[ib] = b;
            stage_next.x[ic] = c;
            stage_next.x[id] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    assign vld_out   = vld_reg;
    assign stage_out = stage_reg;

endmodule
`default_nettype wire

// ===== rtl/chacha_checker.sv =====
`default_nettype none
module chacha_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    out_valid,
    input wire                    out_ready,
    input chacha_pkg::out_item_t  out_item
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item dropped or changed while stalled");

    a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_byte_count == 3'd1 |-> out_item.data_out[31:8] == 24'd0)
        else $error("unused bytes not zero");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_byte_count == 3'd0 |-> out_item.data_out == 32'd0)
        else $error("empty item carries data");

endmodule

bind chacha20_stream_xor chacha_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
`default_nettype wire
